>>> hw/rtl/assert_macros.svh
// Assertion macros for the RTL file that checks its own logic.
// Each macro samples on clk and is disabled while rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a condition at every clock edge.
`define CNV_ASSERT(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Check that a trigger at one edge implies a consequence at the next edge.
`define CNV_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hw/rtl/cnv_pkg.sv
// Package for the centroid / nearest vertex block: widths, codes and payload types.
// No dependencies; the divider, the squarer and the top level refer to it by scoped names.
`default_nettype none

package cnv_pkg;

  localparam int COORD_BITS       = 12;
  localparam int MAX_VERTICES_DEF = 128;
  localparam int WH_W             = 13;
  localparam int CNT_OUT_W        = 8;

  localparam logic [WH_W-1:0] WH_RESET = WH_W'(500);

  typedef logic [COORD_BITS-1:0] coord_t;
  typedef logic [WH_W-1:0]       cfg_item_t;

  typedef enum logic {
    CMD_ADD   = 1'b0,
    CMD_QUERY = 1'b1
  } cmd_t;

  typedef struct packed {
    cmd_t   cmd;
    coord_t x_pos;
    coord_t y_pos;
  } in_item_t;

  typedef struct packed {
    logic [CNT_OUT_W-1:0] vertex_count;
    coord_t               centroid_x;
    coord_t               centroid_y;
    logic [CNT_OUT_W-1:0] nearest_index;
    coord_t               nearest_x;
    coord_t               nearest_y;
    logic                 store_full;
  } out_item_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_status_t;

endpackage

`default_nettype wire

>>> hw/rtl/cnv_chan_if.sv
// Valid/ready channel carrying one payload per transaction.
// The payload type is a parameter.
`default_nettype none

interface cnv_chan_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

>>> hw/rtl/cnv_divider.sv
// Restoring divider, one quotient bit per cycle, shared for both centroid axes.
// Depends on cnv_pkg for the status struct.
`default_nettype none

module cnv_divider #(
  parameter int DVD_W = 20,
  parameter int DVS_W = 8
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             start,
  input  wire logic [DVD_W-1:0] dividend,
  input  wire logic [DVS_W-1:0] divisor,
  output cnv_pkg::div_status_t  status,
  output logic      [DVD_W-1:0] quotient
);

  localparam int STEP_W = $clog2(DVD_W + 1);

  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;
  logic [DVD_W-1:0]  dvd_r, dvd_nxt;
  logic [DVS_W-1:0]  rem_r, rem_nxt;
  logic [DVS_W-1:0]  dvs_r, dvs_nxt;
  logic [DVS_W:0]    rem_sh;
  logic              q_bit;

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    step_nxt = step_r;
    dvd_nxt  = dvd_r;
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    rem_sh   = {rem_r, dvd_r[DVD_W-1]};
    q_bit    = 1'b0;
    if (start) begin
      busy_nxt = 1'b1;
      step_nxt = STEP_W'(DVD_W);
      dvd_nxt  = dividend;
      rem_nxt  = '0;
      dvs_nxt  = divisor;
    end else if (busy_r) begin
      // trial subtract of the shifted remainder
      if (rem_sh >= {1'b0, dvs_r}) begin
        q_bit   = 1'b1;
        rem_nxt = DVS_W'(rem_sh - {1'b0, dvs_r});
      end else begin
        rem_nxt = rem_sh[DVS_W-1:0];
      end
      dvd_nxt  = {dvd_r[DVD_W-2:0], q_bit};
      step_nxt = step_r - STEP_W'(1);
      if (step_r == STEP_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      step_r <= step_nxt;
    end
  end

  always_ff @(posedge clk) begin
    dvd_r <= dvd_nxt;
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
  end

  assign status.busy = busy_r;
  assign status.done = done_r;
  assign quotient    = dvd_r;

endmodule

`default_nettype wire

>>> hw/rtl/cnv_squarer.sv
// Shared squared-difference unit: one multiplier, registered output.
// Depends on cnv_pkg for the coordinate width.
`default_nettype none

module cnv_squarer (
  input  wire logic                              clk,
  input  wire logic [cnv_pkg::COORD_BITS-1:0]    a,
  input  wire logic [cnv_pkg::COORD_BITS-1:0]    b,
  output logic      [2*cnv_pkg::COORD_BITS-1:0]  sq
);

  logic [cnv_pkg::COORD_BITS-1:0]   diff;
  logic [2*cnv_pkg::COORD_BITS-1:0] sq_r;

  assign diff = (a >= b) ? (a - b) : (b - a);

  always_ff @(posedge clk) begin
    sq_r <= diff * diff;
  end

  assign sq = sq_r;

endmodule

`default_nettype wire

>>> hw/rtl/centroid_nearest_vertex.sv
// Top level of the centroid / nearest vertex block: sequencer, vertex memory, output register.
// Depends on cnv_pkg, cnv_chan_if, cnv_divider, cnv_squarer and assert_macros.svh.
//
// Usage:
//   in_chan  carries one command per transaction: an add (store the point, y flipped
//            as window_height-1-y and clamped) or a query (nearest stored vertex).
//   out_chan returns exactly one result transaction per command.
//   cfg_chan writes window_height; it is always ready. Write it only while idle.
// Sequencing:
//   An add goes from acceptance straight to the done state, which loads the result.
//   A query over n stored vertices first sums them through the single memory read
//   port, then makes two passes of the bit-serial divider, then takes each distance
//   through the single shared squarer (centroid first, then each vertex). A query
//   with no stored vertices goes straight to the done state.
//   in_chan.ready is high only while the sequencer is idle.
// Reset: stored count, centroid, nearest index and its coordinates go to zero,
//   window_height to 500. The vertex memory is not cleared; only written entries are read.
// Stall: a finished result waits in the output register; the next command is
//   accepted meanwhile, and its result holds in the sequencer until the register frees.
`default_nettype none
`include "assert_macros.svh"

module centroid_nearest_vertex #(
  parameter int MAX_VERTICES = cnv_pkg::MAX_VERTICES_DEF
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  cnv_chan_if.sink   in_chan,
  cnv_chan_if.source out_chan,
  cnv_chan_if.sink   cfg_chan
);

  localparam int CB     = cnv_pkg::COORD_BITS;
  localparam int CNT_W  = $clog2(MAX_VERTICES + 1);
  localparam int IDX_W  = $clog2(MAX_VERTICES);
  localparam int SUM_W  = CB + CNT_W;
  localparam int DIST_W = 2 * CB + 1;
  localparam int FLIP_W = cnv_pkg::WH_W + 1;

  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_VERTICES);

  typedef enum logic [9:0] {
    ST_IDLE      = 10'b0000000001,
    ST_SUM       = 10'b0000000010,
    ST_DIVX_GO   = 10'b0000000100,
    ST_DIVX_WAIT = 10'b0000001000,
    ST_DIVY_GO   = 10'b0000010000,
    ST_DIVY_WAIT = 10'b0000100000,
    ST_SQX       = 10'b0001000000,
    ST_SQY       = 10'b0010000000,
    ST_CMP       = 10'b0100000000,
    ST_DONE      = 10'b1000000000
  } state_t;

  state_t                   state_r, state_nxt;
  logic [CNT_W-1:0]         count_r, count_nxt;
  logic [CNT_W-1:0]         idx_r, idx_nxt;
  logic                     rdv_r, rdv_nxt;
  logic [SUM_W-1:0]         sum_x_r, sum_x_nxt;
  logic [SUM_W-1:0]         sum_y_r, sum_y_nxt;
  logic [CB-1:0]            px_r, px_nxt;
  logic [CB-1:0]            py_r, py_nxt;
  logic [CB-1:0]            cx_r, cx_nxt;
  logic [CB-1:0]            cy_r, cy_nxt;
  logic [CNT_W-1:0]         best_idx_r, best_idx_nxt;
  logic [CB-1:0]            best_x_r, best_x_nxt;
  logic [CB-1:0]            best_y_r, best_y_nxt;
  logic [DIST_W-1:0]        best_d_r, best_d_nxt;
  logic [2*CB-1:0]          dsum_r, dsum_nxt;
  logic                     ctr_r, ctr_nxt;
  logic                     drop_r, drop_nxt;
  logic [cnv_pkg::WH_W-1:0] wh_r, wh_nxt;
  logic                     out_valid_r, out_valid_nxt;
  cnv_pkg::out_item_t       out_data_r, out_data_nxt;

  // vertex memory: {x, y} per entry, one write and one registered read per cycle
  logic [2*CB-1:0]  vmem [MAX_VERTICES];
  logic [2*CB-1:0]  rd_data_r;
  logic             mem_we;
  logic [IDX_W-1:0] wr_addr;
  logic [2*CB-1:0]  wr_data;
  logic             rd_en;
  logic [IDX_W-1:0] rd_addr;
  logic [CB-1:0]    rd_x, rd_y;

  logic               in_acc;
  logic               cfg_acc;
  logic signed [FLIP_W-1:0] flip_v;
  logic [CB-1:0]      flip_y;
  logic               div_start;
  logic [SUM_W-1:0]   div_dvd;
  logic [SUM_W-1:0]   div_q;
  cnv_pkg::div_status_t div_st;
  logic [CB-1:0]      sq_a, sq_b;
  logic [2*CB-1:0]    sq;
  logic [DIST_W-1:0]  dist_sum;
  logic [CNT_W-1:0]   next_idx;

  assign in_chan.ready  = (state_r == ST_IDLE);
  assign cfg_chan.ready = 1'b1;
  assign in_acc         = in_chan.valid && in_chan.ready;
  assign cfg_acc        = cfg_chan.valid && cfg_chan.ready;

  assign rd_x = rd_data_r[2*CB-1:CB];
  assign rd_y = rd_data_r[CB-1:0];

  // flip y into bottom-up coordinates; clamp to the coordinate range
  assign flip_v = $signed({1'b0, wh_r}) - FLIP_W'(1) - $signed(FLIP_W'(in_chan.data.y_pos));
  always_comb begin
    if (flip_v < 0) begin
      flip_y = '0;
    end else if (flip_v > $signed(FLIP_W'({CB{1'b1}}))) begin
      flip_y = {CB{1'b1}};
    end else begin
      flip_y = flip_v[CB-1:0];
    end
  end

  assign dist_sum = {1'b0, dsum_r} + {1'b0, sq};
  assign next_idx = ctr_r ? '0 : (idx_r + CNT_W'(1));

  cnv_divider #(
    .DVD_W (SUM_W),
    .DVS_W (CNT_W)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dvd),
    .divisor  (count_r),
    .status   (div_st),
    .quotient (div_q)
  );

  cnv_squarer u_sq (
    .clk (clk),
    .a   (sq_a),
    .b   (sq_b),
    .sq  (sq)
  );

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    idx_nxt       = idx_r;
    rdv_nxt       = rdv_r;
    sum_x_nxt     = sum_x_r;
    sum_y_nxt     = sum_y_r;
    px_nxt        = px_r;
    py_nxt        = py_r;
    cx_nxt        = cx_r;
    cy_nxt        = cy_r;
    best_idx_nxt  = best_idx_r;
    best_x_nxt    = best_x_r;
    best_y_nxt    = best_y_r;
    best_d_nxt    = best_d_r;
    dsum_nxt      = dsum_r;
    ctr_nxt       = ctr_r;
    drop_nxt      = drop_r;
    wh_nxt        = wh_r;
    out_valid_nxt = out_valid_r && !out_chan.ready;
    out_data_nxt  = out_data_r;
    mem_we        = 1'b0;
    wr_addr       = count_r[IDX_W-1:0];
    wr_data       = {in_chan.data.x_pos, flip_y};
    rd_en         = 1'b0;
    rd_addr       = idx_r[IDX_W-1:0];
    div_start     = 1'b0;
    div_dvd       = sum_x_r;
    sq_a          = px_r;
    sq_b          = rd_x;

    if (cfg_acc) begin
      wh_nxt = cfg_chan.data;
    end

    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          px_nxt = in_chan.data.x_pos;
          py_nxt = flip_y;
          if (in_chan.data.cmd == cnv_pkg::CMD_ADD) begin
            state_nxt = ST_DONE;
            if (count_r < CNT_MAX) begin
              mem_we    = 1'b1;
              count_nxt = count_r + CNT_W'(1);
              drop_nxt  = 1'b0;
            end else begin
              drop_nxt = 1'b1;
            end
          end else begin
            drop_nxt  = 1'b0;
            idx_nxt   = '0;
            rdv_nxt   = 1'b0;
            sum_x_nxt = '0;
            sum_y_nxt = '0;
            // an empty store keeps centroid and nearest index
            state_nxt = (count_r == '0) ? ST_DONE : ST_SUM;
          end
        end
      end
      ST_SUM: begin
        // issue one read per cycle, accumulate the data in the cycle after its read
        if (rdv_r) begin
          sum_x_nxt = sum_x_r + SUM_W'(rd_x);
          sum_y_nxt = sum_y_r + SUM_W'(rd_y);
        end
        if (idx_r < count_r) begin
          rd_en   = 1'b1;
          idx_nxt = idx_r + CNT_W'(1);
          rdv_nxt = 1'b1;
        end else begin
          rdv_nxt = 1'b0;
          if (!rdv_r) begin
            state_nxt = ST_DIVX_GO;
          end
        end
      end
      ST_DIVX_GO: begin
        div_start = 1'b1;
        div_dvd   = sum_x_r;
        state_nxt = ST_DIVX_WAIT;
      end
      ST_DIVX_WAIT: begin
        if (div_st.done) begin
          cx_nxt    = div_q[CB-1:0];
          state_nxt = ST_DIVY_GO;
        end
      end
      ST_DIVY_GO: begin
        div_start = 1'b1;
        div_dvd   = sum_y_r;
        state_nxt = ST_DIVY_WAIT;
      end
      ST_DIVY_WAIT: begin
        if (div_st.done) begin
          cy_nxt    = div_q[CB-1:0];
          ctr_nxt   = 1'b1;
          state_nxt = ST_SQX;
        end
      end
      ST_SQX: begin
        sq_a      = px_r;
        sq_b      = ctr_r ? cx_r : rd_x;
        state_nxt = ST_SQY;
      end
      ST_SQY: begin
        sq_a      = py_r;
        sq_b      = ctr_r ? cy_r : rd_y;
        dsum_nxt  = sq;
        state_nxt = ST_CMP;
      end
      ST_CMP: begin
        // centroid distance seeds the search; a vertex must be strictly closer
        if (ctr_r) begin
          best_d_nxt = dist_sum;
        end else if (dist_sum < best_d_r) begin
          best_d_nxt   = dist_sum;
          best_idx_nxt = idx_r + CNT_W'(1);
          best_x_nxt   = rd_x;
          best_y_nxt   = rd_y;
        end
        if (next_idx < count_r) begin
          rd_en     = 1'b1;
          rd_addr   = next_idx[IDX_W-1:0];
          idx_nxt   = next_idx;
          ctr_nxt   = 1'b0;
          state_nxt = ST_SQX;
        end else begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        // hold here while the previous result still waits in the output register
        if (!out_valid_r || out_chan.ready) begin
          out_valid_nxt              = 1'b1;
          out_data_nxt.vertex_count  = cnv_pkg::CNT_OUT_W'(count_r);
          out_data_nxt.centroid_x    = cx_r;
          out_data_nxt.centroid_y    = cy_r;
          out_data_nxt.nearest_index = cnv_pkg::CNT_OUT_W'(best_idx_r);
          out_data_nxt.nearest_x     = best_x_r;
          out_data_nxt.nearest_y     = best_y_r;
          out_data_nxt.store_full    = drop_r;
          state_nxt                  = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      idx_r       <= '0;
      rdv_r       <= 1'b0;
      cx_r        <= '0;
      cy_r        <= '0;
      best_idx_r  <= '0;
      best_x_r    <= '0;
      best_y_r    <= '0;
      ctr_r       <= 1'b0;
      drop_r      <= 1'b0;
      wh_r        <= cnv_pkg::WH_RESET;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      idx_r       <= idx_nxt;
      rdv_r       <= rdv_nxt;
      cx_r        <= cx_nxt;
      cy_r        <= cy_nxt;
      best_idx_r  <= best_idx_nxt;
      best_x_r    <= best_x_nxt;
      best_y_r    <= best_y_nxt;
      ctr_r       <= ctr_nxt;
      drop_r      <= drop_nxt;
      wh_r        <= wh_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    sum_x_r    <= sum_x_nxt;
    sum_y_r    <= sum_y_nxt;
    px_r       <= px_nxt;
    py_r       <= py_nxt;
    best_d_r   <= best_d_nxt;
    dsum_r     <= dsum_nxt;
    out_data_r <= out_data_nxt;
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      vmem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= vmem[rd_addr];
    end
  end

  assign out_chan.valid = out_valid_r;
  assign out_chan.data  = out_data_r;

  `CNV_ASSERT(a_best_in_range, best_idx_r <= count_r, "nearest index beyond stored count")
  `CNV_ASSERT(a_div_start_idle, !div_start || !div_st.busy, "divider started while busy")
  `CNV_ASSERT_NEXT(a_add_grows, in_acc && in_chan.data.cmd == cnv_pkg::CMD_ADD && count_r < CNT_MAX, count_r == $past(count_r) + CNT_W'(1), "accepted add did not grow the store")
  `CNV_ASSERT_NEXT(a_full_drop, in_acc && in_chan.data.cmd == cnv_pkg::CMD_ADD && count_r == CNT_MAX, $stable(count_r) && drop_r, "add on a full store not dropped")

endmodule

`default_nettype wire
